@@ src/mf9_pkg.sv @@
// ----------------------------------------------------------------------------
// mf9_pkg: shared types and constants of the 9x9 median filter
// Holds configuration register indexes and widths, the sequencer states and
// the control bundle that drives the row of rank cells.
// ----------------------------------------------------------------------------
package mf9_pkg;

    // configuration port
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

    // input item kind carried on tuser
    localparam logic CMD_DRAIN = 1'b1;

    // per-item sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_LOAD,
        ST_COUNT,
        ST_RANK,
        ST_SELECT,
        ST_DONE
    } t_state;

    // commands to every rank cell
    typedef struct packed {
        logic load;   // capture window tap as key and ring value
        logic count;  // compare key with passing ring value, rotate ring
        logic rank;   // evaluate median hit into the select chain
        logic shift;  // move select chain one cell toward the head
    } t_cell_ctl;

endpackage

@@ src/median_filter_9x9.sv @@
// ----------------------------------------------------------------------------
// median_filter_9x9: streaming square-window median filter
// Takes a raster frame and replaces each interior pixel by its window median.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata = pixel_value, tuser = command (1 = drain item).
//   Master stream: tdata = filtered_pixel, tlast = last_of_frame.
//   Configuration: write image_width (index 0) and image_height (index 1)
//   between frames through i_cfg_we / i_cfg_index / i_cfg_data.
//   Output trails input by WINDOW_RADIUS rows plus WINDOW_RADIUS pixels;
//   after the last pixel send drain items to flush the remaining outputs.
//   Drain items sent inside a frame are dropped without effect.
// Sequencing:
//   One item at a time. Every item reads 2*WINDOW_RADIUS+1 line-store words
//   through the single read port. Interior pixels then run the rank chain:
//   one load step, TAPS = (2*WINDOW_RADIUS+1)^2 ring rotations, one rank
//   step and up to TAPS-1 select shifts.
// Reset: synchronous active-low; positions clear, size returns to 640x480.
// Stall: a result waits in the output register; the next item is still
//   processed and holds in its last state until that register is free.
// ----------------------------------------------------------------------------
module median_filter_9x9
    import mf9_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int PIXEL_BITS    = 8,
    parameter int WINDOW_RADIUS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,  // pixel_value
    input  logic                                s_axis_tuser,  // command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,  // filtered_pixel
    output logic                                m_axis_tlast
);

    localparam int WIN    = 2 * WINDOW_RADIUS + 1;
    localparam int TAPS   = WIN * WIN;
    localparam int ROWS   = 2 * WINDOW_RADIUS;
    localparam int DEPTH  = ROWS * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CB     = $clog2(MAX_WIDTH);
    localparam int ROW_W  = HEIGHT_REG_W + 1;
    localparam int POS_W  = CB + HEIGHT_REG_W + 1;
    localparam int STEP_W = $clog2(ROWS + 2);
    localparam int CNT_W  = $clog2(TAPS);
    localparam int TDW    = ((PIXEL_BITS + 7) / 8) * 8;

    // configuration and derived frame geometry
    logic [WIDTH_REG_W-1:0]  r_cfg_width;
    logic [HEIGHT_REG_W-1:0] r_cfg_height;
    logic [WW-1:0]           w_eff_width;
    logic [HEIGHT_REG_W-1:0] w_eff_height;
    logic [POS_W-1:0]        r_frame;
    logic [POS_W-1:0]        r_delay;
    logic [POS_W-1:0]        r_frame_end;

    // sequencer and raster position
    t_state           r_state;
    t_state           n_state;
    logic [POS_W-1:0] r_pos;
    logic [ROW_W-1:0] r_row;
    logic [CB-1:0]    r_col;
    logic [AW-1:0]    r_addr;

    // current item
    logic [PIXEL_BITS-1:0] r_pix;
    logic                  r_inframe;
    logic                  w_accept;
    logic                  w_in_frame;
    logic                  w_ignore;

    // line-store access
    logic [STEP_W-1:0]     r_step;
    logic [AW-1:0]         r_taddr;
    logic [AW-1:0]         r_kaddr;
    logic [AW-1:0]         w_tap_addr;
    logic [AW-1:0]         w_q_addr;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_mem_we;
    logic [PIXEL_BITS-1:0] w_rd_data;
    logic                  r_rd_vld;
    logic [STEP_W-1:0]     r_rd_idx;
    logic [PIXEL_BITS-1:0] r_col_buf [ROWS];
    logic [PIXEL_BITS-1:0] r_qpix;

    // window and rank chain
    logic [PIXEL_BITS-1:0] r_win [WIN][WIN];
    logic [PIXEL_BITS-1:0] w_win_flat [TAPS];
    logic [PIXEL_BITS-1:0] w_ring [TAPS];
    logic                  w_sel_hit [TAPS];
    logic [PIXEL_BITS-1:0] w_sel_pix [TAPS];
    t_cell_ctl             w_ctl;
    logic [CNT_W-1:0]      r_cnt;

    // shift-stage decisions
    logic w_emit;
    logic w_last;
    logic w_have_med;

    // result and output register
    logic                  r_last;
    logic [PIXEL_BITS-1:0] r_result;
    logic                  w_out_load;
    logic                  r_ovalid;
    logic [PIXEL_BITS-1:0] r_odata;
    logic                  r_olast;

    // clamp the configured size
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff_width = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff_width = WW'(MAX_WIDTH);
        end else begin
            w_eff_width = WW'(r_cfg_width);
        end
        w_eff_height = (r_cfg_height == '0) ? HEIGHT_REG_W'(1) : r_cfg_height;
    end

    // configuration writes and geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame     <= POS_W'(32'(w_eff_width) * 32'(w_eff_height));
        r_delay     <= POS_W'(WINDOW_RADIUS * 32'(w_eff_width) + WINDOW_RADIUS);
        r_frame_end <= r_frame + r_delay;
    end

    // classify the offered item
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_in_frame = r_pos < r_frame;
    assign w_ignore   = w_in_frame && (s_axis_tuser == CMD_DRAIN);

    // tap and border addresses, modulo the store depth
    always_comb begin
        if (32'(r_taddr) >= 32'(w_eff_width)) begin
            w_tap_addr = r_taddr - AW'(w_eff_width);
        end else begin
            w_tap_addr = AW'(32'(r_taddr) + DEPTH - 32'(w_eff_width));
        end
        if (32'(r_kaddr) >= WINDOW_RADIUS) begin
            w_q_addr = r_kaddr - AW'(WINDOW_RADIUS);
        end else begin
            w_q_addr = AW'(32'(r_kaddr) + DEPTH - WINDOW_RADIUS);
        end
    end

    // decisions taken in the shift cycle
    assign w_emit     = r_pos >= r_delay;
    assign w_last     = (r_pos + 1'b1) >= r_frame_end;
    assign w_have_med = r_inframe && (r_row >= ROW_W'(ROWS)) && (r_col >= CB'(ROWS));
    assign w_out_load = (r_state == ST_DONE) && (!r_ovalid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && !w_ignore) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_step == STEP_W'(ROWS + 1)) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!w_emit) begin
                    n_state = ST_IDLE;
                end else if (w_have_med) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LOAD:  n_state = ST_COUNT;
            ST_COUNT: begin
                if (r_cnt == CNT_W'(TAPS - 1)) begin
                    n_state = ST_RANK;
                end
            end
            ST_RANK:  n_state = ST_SELECT;
            ST_SELECT: begin
                if (w_sel_hit[0]) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctl         = '0;
        w_mem_we      = 1'b0;
        w_rd_addr     = w_tap_addr;
        case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_READ: begin
                if (r_step == STEP_W'(ROWS)) begin
                    w_rd_addr = w_q_addr;
                end
            end
            ST_SHIFT:  w_mem_we = r_inframe;
            ST_LOAD:   w_ctl.load = 1'b1;
            ST_COUNT:  w_ctl.count = 1'b1;
            ST_RANK:   w_ctl.rank = 1'b1;
            ST_SELECT: w_ctl.shift = !w_sel_hit[0];
            default: ;
        endcase
    end

    // state register, position and sequencing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_addr   <= '0;
            r_step   <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_READ) && (r_step <= STEP_W'(ROWS));
            r_rd_idx <= r_step;

            // step through the reads
            if (r_state == ST_READ) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end

            // rotation count
            if (r_state == ST_COUNT) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end

            // advance the raster position, or restart after the frame end
            if (r_state == ST_SHIFT) begin
                if (w_emit && w_last) begin
                    r_pos  <= '0;
                    r_row  <= '0;
                    r_col  <= '0;
                    r_addr <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                    if (32'(r_col) + 1 >= 32'(w_eff_width)) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    if (32'(r_addr) == DEPTH - 1) begin
                        r_addr <= '0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
            end
        end
    end

    // item payload and read addressing
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix     <= s_axis_tdata[PIXEL_BITS-1:0];
            r_inframe <= w_in_frame;
            r_taddr   <= r_addr;
        end else if (r_state == ST_READ && r_step < STEP_W'(ROWS)) begin
            r_taddr <= w_tap_addr;
            if (r_step == STEP_W'(WINDOW_RADIUS - 1)) begin
                r_kaddr <= w_tap_addr;
            end
        end
    end

    // collect read data: tap rows arrive from the lowest row upward in index
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_idx < STEP_W'(ROWS)) begin
                r_col_buf[0] <= w_rd_data;
                for (int j = 1; j < ROWS; j++) begin
                    r_col_buf[j] <= r_col_buf[j-1];
                end
            end else begin
                r_qpix <= w_rd_data;
            end
        end
    end

    // shift the window one column for pixels inside the frame
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SHIFT && r_inframe) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN - 1; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
            end
            for (int r = 0; r < ROWS; r++) begin
                r_win[r][WIN-1] <= r_col_buf[r];
            end
            r_win[WIN-1][WIN-1] <= r_pix;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SHIFT) begin
            r_last   <= w_last;
            r_result <= r_qpix;
        end else if (r_state == ST_SELECT && w_sel_hit[0]) begin
            r_result <= w_sel_pix[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odata <= r_result;
            r_olast <= r_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = TDW'(r_odata);
    assign m_axis_tlast  = r_olast;

    mf9_line_store #(
        .DEPTH      (DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_addr),
        .i_wdata (r_pix),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // rank chain: ring rotates toward lower index, select chain too
    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        logic                  w_sel_hit_in;
        logic [PIXEL_BITS-1:0] w_sel_pix_in;

        assign w_win_flat[i] = r_win[i / WIN][i % WIN];

        if (i == TAPS - 1) begin : g_tail
            assign w_sel_hit_in = 1'b0;
            assign w_sel_pix_in = '0;
        end else begin : g_body
            assign w_sel_hit_in = w_sel_hit[i+1];
            assign w_sel_pix_in = w_sel_pix[i+1];
        end

        mf9_rank_cell #(
            .PIXEL_BITS (PIXEL_BITS),
            .TAPS       (TAPS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_win_pix  (w_win_flat[i]),
            .i_ring_pix (w_ring[(i + 1) % TAPS]),
            .o_ring_pix (w_ring[i]),
            .i_sel_hit  (w_sel_hit_in),
            .i_sel_pix  (w_sel_pix_in),
            .o_sel_hit  (w_sel_hit[i]),
            .o_sel_pix  (w_sel_pix[i])
        );
    end

endmodule

@@ src/mf9_line_store.sv @@
// ----------------------------------------------------------------------------
// mf9_line_store: circular pixel store for the previous window rows
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mf9_line_store #(
    parameter int DEPTH      = 8192,
    parameter int PIXEL_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [PIXEL_BITS-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [PIXEL_BITS-1:0]    o_rdata
);

    logic [PIXEL_BITS-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/mf9_rank_cell.sv @@
// ----------------------------------------------------------------------------
// mf9_rank_cell: one cell of the rank chain
// Holds one window pixel as key. The ring of all window pixels rotates past
// the key; the cell counts values below and not above it, then flags itself
// when its key is the median and hands that flag down the select chain.
// ----------------------------------------------------------------------------
module mf9_rank_cell
    import mf9_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int TAPS       = 81
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [PIXEL_BITS-1:0] i_win_pix,
    input  logic [PIXEL_BITS-1:0] i_ring_pix,
    output logic [PIXEL_BITS-1:0] o_ring_pix,
    input  logic                  i_sel_hit,
    input  logic [PIXEL_BITS-1:0] i_sel_pix,
    output logic                  o_sel_hit,
    output logic [PIXEL_BITS-1:0] o_sel_pix
);

    localparam int CW  = $clog2(TAPS + 1);
    localparam int MID = TAPS / 2;

    logic [PIXEL_BITS-1:0] r_key;
    logic [PIXEL_BITS-1:0] r_ring;
    logic [CW-1:0]         r_lt;
    logic [CW-1:0]         r_le;
    logic                  r_sel_hit;
    logic [PIXEL_BITS-1:0] r_sel_pix;

    // load key, rotate ring and count
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key  <= i_win_pix;
            r_ring <= i_win_pix;
            r_lt   <= '0;
            r_le   <= '0;
        end else if (i_ctl.count) begin
            r_ring <= i_ring_pix;
            if (r_ring < r_key) begin
                r_lt <= r_lt + 1'b1;
            end
            if (r_ring <= r_key) begin
                r_le <= r_le + 1'b1;
            end
        end
    end

    // flag median, then pass flags toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.rank) begin
            r_sel_hit <= (r_lt <= CW'(MID)) && (r_le > CW'(MID));
            r_sel_pix <= r_key;
        end else if (i_ctl.shift) begin
            r_sel_hit <= i_sel_hit;
            r_sel_pix <= i_sel_pix;
        end
    end

    assign o_ring_pix = r_ring;
    assign o_sel_hit  = r_sel_hit;
    assign o_sel_pix  = r_sel_pix;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stream-level regression of the 9x9 median filter
// Drives whole frames (pixels, then drain items) through the slave stream,
// predicts every output pixel with a behavioral 9x9 window model, and checks
// the master stream in order. Covers directed corner frames, size extremes
// and random frames under varying source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import mf9_pkg::*;

    localparam logic CMD_PIXEL   = 1'b0;
    localparam int   STORE_WORDS = 8192;
    localparam int   FLUSH_WAIT  = 200;
    localparam int   RAND_PIXELS = 500;

    typedef enum logic [1:0] {ROW_CFG_W, ROW_CFG_H, ROW_PIX, ROW_DRAIN} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [11:0] value;
        logic        typed;     // expected output written into the row
        logic [7:0]  exp_pix;
        logic        exp_last;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } pixel_out_t;

    // 1x1 frame, then 1x2 frame with early drains and a surplus pixel
    localparam dir_row_t DIR_ROWS [24] = '{
        '{ROW_CFG_W, 12'd1, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG_H, 12'd1, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 12'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'hFF, 1'b1},
        '{ROW_CFG_H, 12'd2, 1'b0, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_PIX, 12'h00, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_PIX, 12'hAA, 1'b1, 8'h00, 1'b0},
        '{ROW_PIX, 12'h55, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'h00, 1'b0},
        '{ROW_DRAIN, 12'd0, 1'b1, 8'hAA, 1'b1}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // pixel_value
    logic                   s_axis_tuser;   // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;   // filtered_pixel
    logic                   m_axis_tlast;   // last_of_frame

    // filter model state
    logic [WIDTH_REG_W-1:0]  mdl_width;
    logic [HEIGHT_REG_W-1:0] mdl_height;
    logic [7:0]              line_mem [STORE_WORDS];
    logic [7:0]              win [9][9];
    int unsigned             in_col;
    int unsigned             in_row;
    bit                      frame_closed;

    pixel_out_t pending_pixels [$];
    int         mismatches;
    int         send_gap_pct;
    int         sink_stall_pct;
    int         rand_pixels;

    median_filter_9x9 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // global watchdog
    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // rank 40 of the 81 window taps via histogram
    function automatic logic [7:0] window_median();
        int hist [256];
        int acc;
        for (int v = 0; v < 256; v++) hist[v] = 0;
        for (int r = 0; r < 9; r++)
            for (int c = 0; c < 9; c++) hist[win[r][c]]++;
        acc = 0;
        for (int v = 0; v < 256; v++) begin
            acc += hist[v];
            if (acc > 40) return 8'(v);
        end
        return 8'h00;
    endfunction

    function automatic void step_raster(int unsigned w);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
    endfunction

    // advance the filter model by one accepted transaction
    function automatic void filter_item(input logic cmd, input logic [7:0] pix,
                                        output bit got, output pixel_out_t res);
        int unsigned w, frame, delay, p, addr, q, back, a;
        bit          have;
        logic [7:0]  med;
        got  = 0;
        res  = '0;
        have = 0;
        med  = 8'h00;
        w = (mdl_width == 0) ? 1 : ((mdl_width > 1024) ? 1024 : mdl_width);
        frame = w * ((mdl_height == 0) ? 1 : mdl_height);
        delay = 4 * w + 4;
        p = in_row * w + in_col;
        if (p < frame) begin
            // early drain is dropped
            if (cmd == CMD_DRAIN) return;
            addr = p % STORE_WORDS;
            for (int r = 0; r < 9; r++) begin
                for (int c = 0; c < 8; c++) win[r][c] = win[r][c+1];
                if (r < 8) begin
                    back = ((8 - r) * w) % STORE_WORDS;
                    a = (addr + STORE_WORDS - back) % STORE_WORDS;
                    win[r][8] = line_mem[a];
                end else begin
                    win[r][8] = pix;
                end
            end
            if (in_row >= 8 && in_col >= 8) begin
                have = 1;
                med  = window_median();
            end
            if (p < delay) begin
                line_mem[addr] = pix;
                step_raster(w);
                return;
            end
            q = p - delay;
            res.pix = have ? med : line_mem[q % STORE_WORDS];
            line_mem[addr] = pix;
        end else begin
            if (p < delay) begin
                step_raster(w);
                return;
            end
            q = p - delay;
            res.pix = line_mem[q % STORE_WORDS];
        end
        got = 1;
        res.last = (q + 1 >= frame);
        if (res.last) begin
            in_col = 0;
            in_row = 0;
            frame_closed = 1;
        end else begin
            step_raster(w);
        end
    endfunction

    // drive one transaction, wait for acceptance, record its expected output
    task automatic send_item(input logic cmd, input logic [7:0] pix, input bit typed,
                             input pixel_out_t typed_res);
        bit         got;
        pixel_out_t res;
        @(negedge i_clk);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        filter_item(cmd, pix, got, res);
        if (typed) begin
            if (typed_res != '0 || cmd == CMD_DRAIN && typed_res.last)
                pending_pixels.push_back(typed_res);
            else if (got)
                pending_pixels.push_back(res);
        end else if (got) begin
            pending_pixels.push_back(res);
        end
    endtask

    // drop valid and let the block go quiet
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (FLUSH_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) mdl_width = val[WIDTH_REG_W-1:0];
        else mdl_height = val;
    endtask

    // one full frame: pixels with sporadic early drains, then flush
    task automatic run_frame(input int unsigned w, input int unsigned h, input bit noisy,
                             input bit hold_mid);
        int unsigned n;
        n = ((w == 0) ? 1 : ((w > 1024) ? 1024 : w)) * ((h == 0) ? 1 : h);
        frame_closed = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (noisy && $urandom_range(19) == 0) send_item(CMD_DRAIN, 8'($urandom), 0, '0);
            send_item(CMD_PIXEL, 8'($urandom), 0, '0);
            // hold off until every pending output has arrived
            if (hold_mid && i == n / 2) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (pending_pixels.size() != 0) @(posedge i_clk);
            end
        end
        while (!frame_closed) send_item(CMD_DRAIN, 8'($urandom), 0, '0);
    endtask

    // sink: random back-pressure, check every output transaction
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        pixel_out_t exp_px;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: pixel %h last %b", m_axis_tdata,
                             m_axis_tlast);
            end else begin
                exp_px = pending_pixels.pop_front();
                if (m_axis_tdata !== exp_px.pix || m_axis_tlast !== exp_px.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output mismatch: expected pixel %h last %b, got %h last %b",
                                 exp_px.pix, exp_px.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        pixel_out_t  typed_res;
        int unsigned fw, fh;
        bit          held;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_IMAGE_WIDTH;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_PIXEL;
        m_axis_tready  = 1'b0;
        mismatches     = 0;
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        rand_pixels    = 0;
        held           = 0;
        mdl_width      = WIDTH_RESET;
        mdl_height     = HEIGHT_RESET;
        in_col         = 0;
        in_row         = 0;
        foreach (line_mem[i]) line_mem[i] = 8'h00;
        foreach (win[r, c]) win[r][c] = 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner frames
        foreach (DIR_ROWS[i]) begin
            typed_res = '{pix: DIR_ROWS[i].exp_pix, last: DIR_ROWS[i].exp_last};
            case (DIR_ROWS[i].kind)
                ROW_CFG_W: begin
                    wait_idle();
                    write_reg(CFG_IMAGE_WIDTH, DIR_ROWS[i].value);
                end
                ROW_CFG_H: begin
                    wait_idle();
                    write_reg(CFG_IMAGE_HEIGHT, DIR_ROWS[i].value);
                end
                ROW_PIX: send_item(CMD_PIXEL, DIR_ROWS[i].value[7:0], DIR_ROWS[i].typed,
                                   typed_res);
                default: send_item(CMD_DRAIN, 8'h00, DIR_ROWS[i].typed, typed_res);
            endcase
        end

        // size extremes: out-of-range width, tallest frame, zero sizes
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: begin fw = 9; fh = 9; end
                1: begin fw = 2047; fh = 8; end
                2: begin fw = 1; fh = 4095; end
                3: begin fw = 0; fh = 0; end
                default: begin fw = 17; fh = 10; end
            endcase
            wait_idle();
            write_reg(CFG_IMAGE_WIDTH, 12'(fw));
            write_reg(CFG_IMAGE_HEIGHT, 12'(fh));
            run_frame(fw, fh, 1, 0);
        end

        // random frames across three idling regimes
        while (rand_pixels < RAND_PIXELS) begin
            case (rand_pixels * 3 / RAND_PIXELS)
                0: begin send_gap_pct = 27; sink_stall_pct = 53; end
                1: begin send_gap_pct = 53; sink_stall_pct = 27; end
                default: begin send_gap_pct = 0; sink_stall_pct = 0; end
            endcase
            if ($urandom_range(5) == 0) begin
                fw = $urandom_range(1, 8);
                fh = $urandom_range(1, 8);
            end else begin
                fw = $urandom_range(9, 16);
                fh = $urandom_range(9, 12);
            end
            wait_idle();
            write_reg(CFG_IMAGE_WIDTH, 12'(fw));
            write_reg(CFG_IMAGE_HEIGHT, 12'(fh));
            run_frame(fw, fh, 1, !held);
            held = 1;
            rand_pixels += fw * fh;
        end

        wait_idle();
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
